// ===== hdl/dnrf_pkg.sv =====
// Shared definitions for the device number range filter.
// Request codes, number width and the control bundle for the word unit.
// No dependencies.
package dnrf_pkg;

    localparam int DNRF_NUMBER_COUNT = 65536;
    localparam int DNRF_WORD_BITS    = 64;

    // Width of the request fields, and of internal numbers (must hold NUMBER_COUNT).
    localparam int FIELD_W = 16;
    localparam int NUM_W   = 17;

    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_FREE     = 3'd1;
    localparam logic [2:0] REQ_FREE_ALL = 3'd2;
    localparam logic [2:0] REQ_TEST     = 3'd3;
    localparam logic [2:0] REQ_FIND     = 3'd4;

    typedef struct packed {
        logic [2:0]       req;
        logic [NUM_W-1:0] base;    // number of bit 0 of the word on the read port
        logic [NUM_W-1:0] lo_num;  // range start
        logic [NUM_W-1:0] hi_num;  // range end, exclusive
        logic [NUM_W-1:0] query;
        logic [NUM_W-1:0] start;   // search start
        logic [NUM_W-1:0] zfrom;   // first number checked for a clear bit
        logic             open;    // run started, looking for its end
    } dnrf_ctl_t;

    typedef struct packed {
        logic listed;
        logic cand_any;
    } dnrf_stat_t;

    function automatic logic [NUM_W-1:0] to_num(input logic [FIELD_W-1:0] v);
        to_num = {{(NUM_W - FIELD_W){1'b0}}, v};
    endfunction

endpackage

// ===== hdl/dnrf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dnrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dnrf_word_unit.sv =====
// Per-word logic: range masks for set/clear, bit test, and the
// lowest-candidate search used to find run starts and run ends.
// Depends on dnrf_pkg.
module dnrf_word_unit
    import dnrf_pkg::*;
#(
    parameter int WORD_BITS = DNRF_WORD_BITS,
    localparam int IDX_W = $clog2(WORD_BITS),
    localparam int OFF_W = $clog2(WORD_BITS + 1)
) (
    input  dnrf_ctl_t            ctl,
    input  logic [WORD_BITS-1:0] rd_word,
    output logic [WORD_BITS-1:0] wr_word,
    output dnrf_stat_t           stat,
    output logic [IDX_W-1:0]     idx
);

    // Offset of num inside the word at base, clamped to 0..WORD_BITS.
    function automatic logic [OFF_W-1:0] word_off(input logic [NUM_W-1:0] num,
                                                  input logic [NUM_W-1:0] base);
        logic [NUM_W-1:0] diff;
        diff = num - base;
        if (num <= base)
        begin
            word_off = '0;
        end
        else if (diff >= NUM_W'(WORD_BITS))
        begin
            word_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            word_off = diff[OFF_W-1:0];
        end
    endfunction

    function automatic logic [WORD_BITS-1:0] ge_mask(input logic [OFF_W-1:0] off);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (OFF_W'(i) >= off);
        end
        ge_mask = m;
    endfunction

    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] query_mask;
    logic [OFF_W-1:0]     scan_off;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lowest;

    always_comb
    begin
        range_mask = ge_mask(word_off(ctl.lo_num, ctl.base))
                   & ~ge_mask(word_off(ctl.hi_num, ctl.base));
        query_mask = ge_mask(word_off(ctl.query, ctl.base))
                   & ~ge_mask(word_off(ctl.query + NUM_W'(1), ctl.base));

        if (ctl.req == REQ_ADD)
        begin
            wr_word = rd_word | range_mask;
        end
        else
        begin
            wr_word = rd_word & ~range_mask;
        end

        // Before a run: first set bit at or after start. Inside a run: first clear bit.
        scan_off = ctl.open ? word_off(ctl.zfrom, ctl.base) : word_off(ctl.start, ctl.base);
        cand     = (ctl.open ? ~rd_word : rd_word) & ge_mask(scan_off);
        lowest   = cand & (~cand + WORD_BITS'(1));

        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            for (int j = 0; j < IDX_W; j++)
            begin
                if (((i >> j) & 1) == 1)
                begin
                    idx[j] = idx[j] | lowest[i];
                end
            end
        end

        stat.listed   = |(rd_word & query_mask);
        stat.cand_any = |cand;
    end

endmodule

// ===== hdl/device_number_range_filter_unit.sv =====
// Device number range filter: top level with the request sequencer and map RAM.
// Depends on dnrf_pkg, dnrf_ram and dnrf_word_unit.
//
// Keeps one ignore bit per device number in a RAM of MAP_WORDS = NUMBER_COUNT/WORD_BITS
// words, rounded up (1024 by default), and gives one result beat per request. Add, free
// and test walk every map word through a read-modify-write pipeline at one word per
// cycle; find-next-run walks the same way but stops as soon as the run end is seen and
// holds the word where the run starts to look for the end in it too. Free all is a write
// sweep over every map word. Rejected ranges, ranges that start past the map and unused
// codes go to the result without a walk. After reset a clearing pass over every map word
// runs with in_stall high. One request is in work at a time; a finished result sits in
// the output register while the next request is taken.
module device_number_range_filter_unit
    import dnrf_pkg::*;
#(
    parameter int NUMBER_COUNT = DNRF_NUMBER_COUNT,
    parameter int WORD_BITS    = DNRF_WORD_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [FIELD_W-1:0] range_first,
    input  logic [FIELD_W-1:0] range_last,
    input  logic [FIELD_W-1:0] query_number,
    input  logic [FIELD_W-1:0] scan_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_listed,
    output logic               range_error,
    output logic               run_found,
    output logic [FIELD_W-1:0] run_first,
    output logic [FIELD_W-1:0] run_last
);

    localparam int MAP_WORDS = (NUMBER_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = $clog2(WORD_BITS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
    localparam logic [NUM_W-1:0]  NUM_LIMIT = NUM_W'(NUMBER_COUNT);
    localparam logic [NUM_W-1:0]  NUM_TOP   = NUM_W'(NUMBER_COUNT - 1);
    localparam logic [NUM_W-1:0]  WORD_STEP = NUM_W'(WORD_BITS);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // control
    logic [1:0]        state_reg, state_next;
    logic              clr_req_reg, clr_req_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              rd_more_reg, rd_more_next;
    logic              proc_valid_reg, proc_valid_next;
    logic              open_reg, open_next;
    logic              hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [2:0]         req_reg, req_next;
    logic [NUM_W-1:0]   lo_reg, lo_next;
    logic [NUM_W-1:0]   hi_reg, hi_next;
    logic [NUM_W-1:0]   query_reg, query_next;
    logic [NUM_W-1:0]   start_reg, start_next;
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [NUM_W-1:0]   rd_base_reg, rd_base_next;
    logic [ADDR_W-1:0]  proc_addr_reg, proc_addr_next;
    logic [NUM_W-1:0]   proc_base_reg, proc_base_next;
    logic               res_listed_reg, res_listed_next;
    logic               res_err_reg, res_err_next;
    logic               res_found_reg, res_found_next;
    logic [NUM_W-1:0]   first_num_reg, first_num_next;
    logic [NUM_W-1:0]   last_num_reg, last_num_next;
    logic               is_listed_reg, is_listed_next;
    logic               range_error_reg, range_error_next;
    logic               run_found_reg, run_found_next;
    logic [FIELD_W-1:0] run_first_reg, run_first_next;
    logic [FIELD_W-1:0] run_last_reg, run_last_next;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WORD_BITS-1:0] ram_rd_data;

    dnrf_ctl_t            ctl;
    dnrf_stat_t           stat;
    logic [WORD_BITS-1:0] unit_wr_word;
    logic [IDX_W-1:0]     unit_idx;

    logic [FIELD_W-1:0] eff_last;
    logic [NUM_W-1:0]   clip_last;
    logic               is_find;
    logic               found_start;
    logic               found_end;

    dnrf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    dnrf_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .ctl     (ctl),
        .rd_word (ram_rd_data),
        .wr_word (unit_wr_word),
        .stat    (stat),
        .idx     (unit_idx)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        ctl.req    = req_reg;
        ctl.base   = proc_base_reg;
        ctl.lo_num = lo_reg;
        ctl.hi_num = hi_reg;
        ctl.query  = query_reg;
        ctl.start  = start_reg;
        ctl.zfrom  = hold_reg ? (first_num_reg + NUM_W'(1)) : '0;
        ctl.open   = open_reg;
    end

    always_comb
    begin
        eff_last  = (range_last == '0) ? range_first : range_last;
        clip_last = (to_num(eff_last) > NUM_TOP) ? NUM_TOP : to_num(eff_last);

        is_find     = (req_reg == REQ_FIND);
        found_start = proc_valid_reg && is_find && !open_reg && stat.cand_any;
        found_end   = proc_valid_reg && is_find && open_reg && stat.cand_any;

        state_next       = state_reg;
        clr_req_next     = clr_req_reg;
        clr_addr_next    = clr_addr_reg;
        rd_more_next     = rd_more_reg;
        proc_valid_next  = proc_valid_reg;
        open_next        = open_reg;
        hold_next        = 1'b0;
        out_valid_next   = out_valid_reg;
        req_next         = req_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        query_next       = query_reg;
        start_next       = start_reg;
        rd_addr_next     = rd_addr_reg;
        rd_base_next     = rd_base_reg;
        proc_addr_next   = proc_addr_reg;
        proc_base_next   = proc_base_reg;
        res_listed_next  = res_listed_reg;
        res_err_next     = res_err_reg;
        res_found_next   = res_found_reg;
        first_num_next   = first_num_reg;
        last_num_next    = last_num_reg;
        is_listed_next   = is_listed_reg;
        range_error_next = range_error_reg;
        run_found_next   = run_found_reg;
        run_first_next   = run_first_reg;
        run_last_next    = run_last_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = proc_addr_reg;
        ram_wr_data = unit_wr_word;
        ram_rd_en   = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = clr_req_reg ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    lo_next         = to_num(range_first);
                    hi_next         = clip_last + NUM_W'(1);
                    query_next      = to_num(query_number);
                    start_next      = to_num(scan_start);
                    res_listed_next = 1'b0;
                    res_err_next    = 1'b0;
                    res_found_next  = 1'b0;
                    first_num_next  = '0;
                    last_num_next   = '0;
                    rd_addr_next    = '0;
                    rd_base_next    = '0;
                    rd_more_next    = 1'b1;
                    proc_valid_next = 1'b0;
                    open_next       = 1'b0;
                    unique case (req_type)
                        REQ_ADD, REQ_FREE:
                        begin
                            if (range_first > eff_last)
                            begin
                                res_err_next = 1'b1;
                                state_next   = ST_FINISH;
                            end
                            else if (to_num(range_first) >= NUM_LIMIT)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        REQ_FREE_ALL:
                        begin
                            clr_req_next  = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        REQ_TEST, REQ_FIND:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Reads run one word ahead of the write-back, so the two never meet.
                if (rd_more_reg && !found_start && !found_end)
                begin
                    ram_rd_en       = 1'b1;
                    proc_valid_next = 1'b1;
                    proc_addr_next  = rd_addr_reg;
                    proc_base_next  = rd_base_reg;
                    rd_addr_next    = rd_addr_reg + ADDR_W'(1);
                    rd_base_next    = rd_base_reg + WORD_STEP;
                    rd_more_next    = (rd_addr_reg != LAST_ADDR);
                end
                else if (!found_start)
                begin
                    proc_valid_next = 1'b0;
                end

                if (proc_valid_reg)
                begin
                    if (req_reg == REQ_ADD || req_reg == REQ_FREE)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    if (req_reg == REQ_TEST && stat.listed)
                    begin
                        res_listed_next = 1'b1;
                    end
                end

                // Run start found: hold the word to look for its end in it too.
                if (found_start)
                begin
                    hold_next      = 1'b1;
                    open_next      = 1'b1;
                    res_found_next = 1'b1;
                    first_num_next = proc_base_reg + NUM_W'(unit_idx);
                end
                else if (found_end)
                begin
                    last_num_next = proc_base_reg + NUM_W'(unit_idx) - NUM_W'(1);
                    state_next    = ST_FINISH;
                end
                else if (proc_valid_reg && proc_addr_reg == LAST_ADDR)
                begin
                    if (is_find && open_reg)
                    begin
                        last_num_next = NUM_TOP;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    is_listed_next   = res_listed_reg;
                    range_error_next = res_err_reg;
                    run_found_next   = res_found_reg;
                    run_first_next   = first_num_reg[FIELD_W-1:0];
                    run_last_next    = last_num_reg[FIELD_W-1:0];
                    out_valid_next   = 1'b1;
                    clr_req_next     = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_req_reg    <= 1'b0;
            clr_addr_reg   <= '0;
            rd_more_reg    <= 1'b0;
            proc_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            hold_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_req_reg    <= clr_req_next;
            clr_addr_reg   <= clr_addr_next;
            rd_more_reg    <= rd_more_next;
            proc_valid_reg <= proc_valid_next;
            open_reg       <= open_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        query_reg       <= query_next;
        start_reg       <= start_next;
        rd_addr_reg     <= rd_addr_next;
        rd_base_reg     <= rd_base_next;
        proc_addr_reg   <= proc_addr_next;
        proc_base_reg   <= proc_base_next;
        res_listed_reg  <= res_listed_next;
        res_err_reg     <= res_err_next;
        res_found_reg   <= res_found_next;
        first_num_reg   <= first_num_next;
        last_num_reg    <= last_num_next;
        is_listed_reg   <= is_listed_next;
        range_error_reg <= range_error_next;
        run_found_reg   <= run_found_next;
        run_first_reg   <= run_first_next;
        run_last_reg    <= run_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_listed   = is_listed_reg;
    assign range_error = range_error_reg;
    assign run_found   = run_found_reg;
    assign run_first   = run_first_reg;
    assign run_last    = run_last_reg;

    a_no_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != rd_addr_reg))
        else $error("map read and write hit the same word");

    a_hold_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |=> !hold_reg)
        else $error("run start word held more than one cycle");

    a_beat_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result beat raised outside finish");

    a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_found_reg) |-> (first_num_reg <= last_num_reg))
        else $error("run end before run start");

endmodule

// ===== bench/ignore_map_checker.sv =====
// Checker for the device number range filter: watches both channels, keeps its own
// copy of the ignore map and compares every result beat with the predicted one.
// Depends on dnrf_pkg for request codes, field width and map geometry.
module ignore_map_checker
    import dnrf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [FIELD_W-1:0] range_first,
    input  logic [FIELD_W-1:0] range_last,
    input  logic [FIELD_W-1:0] query_number,
    input  logic [FIELD_W-1:0] scan_start,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               is_listed,
    input  logic               range_error,
    input  logic               run_found,
    input  logic [FIELD_W-1:0] run_first,
    input  logic [FIELD_W-1:0] run_last,
    output int                 mismatches,
    output int                 awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_NUMBERS = DNRF_NUMBER_COUNT;
    localparam int WORD        = DNRF_WORD_BITS;
    localparam int MAP_WORDS   = MAP_NUMBERS / WORD;

    typedef struct packed {
        bit               listed;
        bit               rejected;
        bit               found;
        bit [FIELD_W-1:0] run_lo;
        bit [FIELD_W-1:0] run_hi;
    } filter_result_t;

    bit [WORD-1:0]  ign_words [MAP_WORDS];
    filter_result_t expected_results [$];

    function automatic bit number_ignored(int n);
        if (n >= MAP_NUMBERS)
            return 1'b0;
        return ign_words[n / WORD][n % WORD];
    endfunction

    // whole aligned words are written at once, edges bit by bit
    function automatic void mark_range(int lo, int hi, bit value);
        int n;
        n = lo;
        while (n <= hi)
        begin
            if (n % WORD == 0 && n + WORD - 1 <= hi)
            begin
                ign_words[n / WORD] = {WORD{value}};
                n += WORD;
            end
            else
            begin
                ign_words[n / WORD][n % WORD] = value;
                n++;
            end
        end
    endfunction

    function automatic filter_result_t apply_request(bit [2:0] kind, bit [FIELD_W-1:0] first,
                                                     bit [FIELD_W-1:0] last_num,
                                                     bit [FIELD_W-1:0] query,
                                                     bit [FIELD_W-1:0] start);
        filter_result_t r;
        int lo;
        int hi;
        int n;
        int e;
        r  = '0;
        lo = int'(first);
        hi = (last_num == 0) ? int'(first) : int'(last_num);
        case (kind)
            REQ_ADD, REQ_FREE:
            begin
                if (lo > hi)
                    r.rejected = 1'b1;
                else if (lo < MAP_NUMBERS)
                    mark_range(lo, (hi > MAP_NUMBERS - 1) ? MAP_NUMBERS - 1 : hi,
                               kind == REQ_ADD);
            end
            REQ_FREE_ALL:
            begin
                foreach (ign_words[i])
                    ign_words[i] = '0;
            end
            REQ_TEST:
                r.listed = number_ignored(int'(query));
            REQ_FIND:
            begin
                n = int'(start);
                while (n < MAP_NUMBERS && !number_ignored(n))
                begin
                    if (ign_words[n / WORD] == '0)
                        n = (n / WORD + 1) * WORD;
                    else
                        n++;
                end
                if (n < MAP_NUMBERS)
                begin
                    e = n;
                    while (e + 1 < MAP_NUMBERS && number_ignored(e + 1))
                    begin
                        if ((e + 1) % WORD == 0 && ign_words[(e + 1) / WORD] == '1)
                            e += WORD;
                        else
                            e++;
                    end
                    r.found  = 1'b1;
                    r.run_lo = n[FIELD_W-1:0];
                    r.run_hi = e[FIELD_W-1:0];
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        if (!rst_n)
        begin
            foreach (ign_words[i])
                ign_words[i] = '0;
            expected_results.delete();
            awaited = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("is_listed", int'(want.listed), int'(is_listed));
                    check_field("range_error", int'(want.rejected), int'(range_error));
                    check_field("run_found", int'(want.found), int'(run_found));
                    check_field("run_first", int'(want.run_lo), int'(run_first));
                    check_field("run_last", int'(want.run_hi), int'(run_last));
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(req_type, range_first, range_last,
                                                         query_number, scan_start));
            awaited = expected_results.size();
        end
    end

endmodule

// ===== bench/device_number_range_filter_unit_tb.sv =====
// Top of the device number range filter bench: clock, reset, request stimulus,
// result-side stall and the verdict. Depends on dnrf_pkg, the filter unit and
// ignore_map_checker.
module device_number_range_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dnrf_pkg::*;

    localparam int QUIET_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int RANDOM_ITEMS = 580;
    localparam int TOP_NUMBER   = DNRF_NUMBER_COUNT - 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         req_type = REQ_TEST;
    logic [FIELD_W-1:0] range_first = '0;
    logic [FIELD_W-1:0] range_last = '0;
    logic [FIELD_W-1:0] query_number = '0;
    logic [FIELD_W-1:0] scan_start = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               is_listed;
    logic               range_error;
    logic               run_found;
    logic [FIELD_W-1:0] run_first;
    logic [FIELD_W-1:0] run_last;

    int                 mismatches;
    int                 awaited;
    int                 quiet_cycles = 0;
    bit                 calm = 1'b0;
    bit [FIELD_W-1:0]   hot_number = '0;

    device_number_range_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .range_first  (range_first),
        .range_last   (range_last),
        .query_number (query_number),
        .scan_start   (scan_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_listed    (is_listed),
        .range_error  (range_error),
        .run_found    (run_found),
        .run_first    (run_first),
        .run_last     (run_last)
    );

    ignore_map_checker ignore_map_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .range_first  (range_first),
        .range_last   (range_last),
        .query_number (query_number),
        .scan_start   (scan_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_listed    (is_listed),
        .range_error  (range_error),
        .run_found    (run_found),
        .run_first    (run_first),
        .run_last     (run_last),
        .mismatches   (mismatches),
        .awaited      (awaited)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 34);

    // nothing moving on either channel for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("device_number_range_filter_unit_tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic issue_request(logic [2:0] kind, logic [FIELD_W-1:0] first,
                                 logic [FIELD_W-1:0] last_num, logic [FIELD_W-1:0] query,
                                 logic [FIELD_W-1:0] start);
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        range_first  <= first;
        range_last   <= last_num;
        query_number <= query;
        scan_start   <= start;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic random_request();
        int               pick;
        int               width;
        logic [2:0]       kind;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] last_num;
        logic [FIELD_W-1:0] query;
        logic [FIELD_W-1:0] start;
        first    = FIELD_W'($urandom);
        last_num = FIELD_W'($urandom);
        query    = FIELD_W'($urandom);
        start    = FIELD_W'($urandom);
        pick     = $urandom_range(99);
        if (pick < 26)
            kind = REQ_ADD;
        else if (pick < 46)
            kind = REQ_FREE;
        else if (pick < 50)
            kind = REQ_FREE_ALL;
        else if (pick < 70)
            kind = REQ_TEST;
        else if (pick < 94)
            kind = REQ_FIND;
        else
            kind = 3'($urandom_range(7, REQ_FIND + 1));

        if (kind == REQ_ADD || kind == REQ_FREE)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // start above end: rejected
                first    = FIELD_W'($urandom_range(TOP_NUMBER, 2));
                last_num = FIELD_W'($urandom_range(int'(first) - 1, 1));
            end
            else
            begin
                if ($urandom_range(99) < 60)
                    first = FIELD_W'(hot_number + $urandom_range(300) - 150);
                if (pick < 60)
                    width = $urandom_range(70);
                else if (pick < 85)
                    width = $urandom_range(2000);
                else
                    width = $urandom_range(TOP_NUMBER);
                last_num = (int'(first) + width > TOP_NUMBER) ? FIELD_W'(TOP_NUMBER)
                                                             : FIELD_W'(int'(first) + width);
                if ($urandom_range(9) == 0)
                    last_num = '0;
                hot_number = first;
            end
        end
        else if (kind == REQ_TEST && $urandom_range(99) < 70)
            query = FIELD_W'(hot_number + $urandom_range(400) - 200);
        else if (kind == REQ_FIND && $urandom_range(99) < 60)
            start = FIELD_W'(hot_number + $urandom_range(400) - 200);
        issue_request(kind, first, last_num, query, start);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty map
        issue_request(REQ_TEST, '0, '0, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, '0);
        // single numbers via zero end, at both extremes
        issue_request(REQ_ADD, '0, '0, '1, '1);
        issue_request(REQ_TEST, '1, '1, '0, '1);
        issue_request(REQ_ADD, '1, '0, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, 16'd65530);
        // run across word boundaries, rejected ranges, a hole punched by free
        issue_request(REQ_ADD, 16'd100, 16'd511, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, 16'd1);
        issue_request(REQ_ADD, 16'd500, 16'd20, '0, '0);
        issue_request(REQ_FREE, 16'd7, 16'd3, '0, '0);
        issue_request(REQ_FREE, 16'd200, 16'd300, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, 16'd1);
        issue_request(REQ_FIND, '0, '0, '0, 16'd250);
        for (int k = REQ_FIND + 1; k < 8; k++)
            issue_request(3'(k), FIELD_W'($urandom), FIELD_W'($urandom),
                          FIELD_W'($urandom), FIELD_W'($urandom));
        issue_request(REQ_FREE_ALL, '1, '1, '1, '1);
        issue_request(REQ_FIND, '0, '0, '0, '0);
        // whole map set, then number 1 and the top number freed
        issue_request(REQ_ADD, '0, '1, '0, '0);
        issue_request(REQ_FIND, '0, '0, '0, 16'd12345);
        issue_request(REQ_FREE, 16'd1, '0, '0, '0);
        issue_request(REQ_FREE, '1, '1, '0, '0);
        issue_request(REQ_TEST, '0, '0, '1, '0);
        issue_request(REQ_FIND, '0, '0, '0, 16'd2);
        issue_request(REQ_FREE_ALL, '0, '0, '0, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 200 && i < 300);
            random_request();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (awaited == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && awaited == 0)
            $display("device_number_range_filter_unit_tb: clean");
        else
            $display("device_number_range_filter_unit_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dnrf_pkg.sv
hdl/dnrf_ram.sv
hdl/dnrf_word_unit.sv
hdl/device_number_range_filter_unit.sv
bench/ignore_map_checker.sv
bench/device_number_range_filter_unit_tb.sv
